// ===== design/four_neighbour_local_maximum_core_defines.svh =====
`ifndef FOUR_NEIGHBOUR_LOCAL_MAXIMUM_CORE_DEFINES_SVH
`define FOUR_NEIGHBOUR_LOCAL_MAXIMUM_CORE_DEFINES_SVH

// check on every clock edge outside reset
`define FNLM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// check on every clock edge, reset included
`define FNLM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/fnlm_pkg.sv =====
`default_nettype none

package fnlm_pkg;

   localparam int CFG_W          = 7;
   localparam int CSR_INDEX_W    = 2;
   localparam int MIN_SIZE       = 3;
   localparam int CFG_RESET_SIZE = 64;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_ROWS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_COLS = 2'd1;

   typedef enum logic [1:0] {
      KIND_PEAK      = 2'd0,
      KIND_END_FOUND = 2'd1,
      KIND_END_NONE  = 2'd2
   } result_kind_type;

endpackage

`default_nettype wire

// ===== design/fnlm_ram.sv =====
`default_nettype none

module fnlm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output      logic [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output      logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

// ===== design/four_neighbour_local_maximum_core.sv =====
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_ready   element_value
// rsp      out        rsp_valid/rsp_ready   result_kind, peak_value, peak_row, peak_col
// csr      in         csr_write_en          csr_index, csr_wdata
//
// One element per cycle while req_ready is high: the line buffer RAM is read
// in the cycle before, at the next column and the one after it, so the four
// compares and the write-back share the cycle of the req transfer.
// A result appears on rsp in the cycle after the element that decides it.
// req_ready drops only while a result waits in the output register.
// Synchronous reset clears positions and flags; line buffers need no clearing.

`default_nettype none

module four_neighbour_local_maximum_core #(
   parameter int MAX_COLS   = 64,
   parameter int MAX_ROWS   = 64,
   parameter int DATA_WIDTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output      logic                                   req_ready,
   input  wire logic signed [DATA_WIDTH-1:0]           req_element_value,
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_ready,
   output      fnlm_pkg::result_kind_type              rsp_result_kind,
   output      logic signed [DATA_WIDTH-1:0]           rsp_peak_value,
   output      logic [$clog2(MAX_ROWS+1)-1:0]          rsp_peak_row,
   output      logic [$clog2(MAX_COLS+1)-1:0]          rsp_peak_col,
   input  wire logic                                   csr_write_en,
   input  wire logic [fnlm_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [fnlm_pkg::CFG_W-1:0]             csr_wdata
);

   localparam int ROW_W      = $clog2(MAX_ROWS + 1);
   localparam int COL_W      = $clog2(MAX_COLS + 1);
   localparam int ROW_IDX_W  = $clog2(MAX_ROWS);
   localparam int COL_IDX_W  = $clog2(MAX_COLS);
   localparam int WORD_W     = 2 * DATA_WIDTH;
   localparam int ROWS_RESET =
      (MAX_ROWS < fnlm_pkg::CFG_RESET_SIZE) ? MAX_ROWS : fnlm_pkg::CFG_RESET_SIZE;
   localparam int COLS_RESET =
      (MAX_COLS < fnlm_pkg::CFG_RESET_SIZE) ? MAX_COLS : fnlm_pkg::CFG_RESET_SIZE;

   logic [ROW_W-1:0]     rows_ff, rows_in;
   logic [COL_W-1:0]     cols_ff, cols_in;
   logic [ROW_IDX_W-1:0] row_ff, row_in;
   logic [COL_IDX_W-1:0] col_ff, col_in;
   logic                 found_ff, found_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   fnlm_pkg::result_kind_type    kind_ff, kind_in;
   logic signed [DATA_WIDTH-1:0] value_ff, value_in;
   logic [ROW_W-1:0]             prow_ff, prow_in;
   logic [COL_W-1:0]             pcol_ff, pcol_in;
   logic signed [DATA_WIDTH-1:0] left_ff;

   logic [WORD_W-1:0]            word_cur;
   logic [WORD_W-1:0]            word_next;
   logic signed [DATA_WIDTH-1:0] centre, up, right;
   logic                         accept, cfg_hit, col_last, row_last;
   logic                         emit, frame_end;
   logic [31:0]                  wdata_wide;
   logic [COL_IDX_W-1:0]         rd_addr_next;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign cfg_hit   = csr_write_en &&
                      (csr_index == fnlm_pkg::REG_FRAME_ROWS ||
                       csr_index == fnlm_pkg::REG_FRAME_COLS);

   assign col_last  = (COL_W'(col_ff) + COL_W'(1)) == cols_ff;
   assign row_last  = (ROW_W'(row_ff) + ROW_W'(1)) == rows_ff;

   assign centre = $signed(word_cur[DATA_WIDTH-1:0]);
   assign up     = $signed(word_cur[WORD_W-1:DATA_WIDTH]);
   assign right  = $signed(word_next[DATA_WIDTH-1:0]);

   assign emit = (row_ff >= ROW_IDX_W'(2)) && (col_ff != '0) && !col_last &&
                 (centre > left_ff) && (centre > right) &&
                 (centre > up) && (centre > req_element_value);
   assign frame_end = col_last && row_last;

   // frame size, clamped on write
   assign wdata_wide = 32'(csr_wdata);

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_write_en && csr_index == fnlm_pkg::REG_FRAME_ROWS) begin
         if (wdata_wide < 32'(fnlm_pkg::MIN_SIZE)) begin
            rows_in = ROW_W'(fnlm_pkg::MIN_SIZE);
         end else if (wdata_wide > 32'(MAX_ROWS)) begin
            rows_in = ROW_W'(MAX_ROWS);
         end else begin
            rows_in = ROW_W'(csr_wdata);
         end
      end
      if (csr_write_en && csr_index == fnlm_pkg::REG_FRAME_COLS) begin
         if (wdata_wide < 32'(fnlm_pkg::MIN_SIZE)) begin
            cols_in = COL_W'(fnlm_pkg::MIN_SIZE);
         end else if (wdata_wide > 32'(MAX_COLS)) begin
            cols_in = COL_W'(MAX_COLS);
         end else begin
            cols_in = COL_W'(csr_wdata);
         end
      end
   end

   // raster position
   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      found_in = found_ff;
      if (cfg_hit) begin
         row_in   = '0;
         col_in   = '0;
         found_in = 1'b0;
      end else if (accept) begin
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               row_in   = '0;
               found_in = 1'b0;
            end else begin
               row_in = row_ff + ROW_IDX_W'(1);
            end
         end else begin
            col_in   = col_ff + COL_IDX_W'(1);
            found_in = found_ff || emit;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      value_in     = value_ff;
      prow_in      = prow_ff;
      pcol_in      = pcol_ff;
      if (accept && frame_end) begin
         rsp_valid_in = 1'b1;
         kind_in      = found_ff ? fnlm_pkg::KIND_END_FOUND : fnlm_pkg::KIND_END_NONE;
         value_in     = '0;
         prow_in      = rows_ff;
         pcol_in      = cols_ff;
      end else if (accept && emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = fnlm_pkg::KIND_PEAK;
         value_in     = centre;
         prow_in      = ROW_W'(row_ff);
         pcol_in      = COL_W'(col_ff) + COL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= ROW_W'(ROWS_RESET);
         cols_ff      <= COL_W'(COLS_RESET);
         row_ff       <= '0;
         col_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      prow_ff  <= prow_in;
      pcol_ff  <= pcol_in;
      if (accept) begin
         left_ff <= centre;
      end
   end

   // prefetch the next column and its right neighbor
   assign rd_addr_next = col_in + COL_IDX_W'(1);

   fnlm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_COLS)
   ) u_line_ram (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (col_ff),
      .wr_data   ({centre, req_element_value}),
      .rd_addr_a (col_in),
      .rd_data_a (word_cur),
      .rd_addr_b (rd_addr_next),
      .rd_data_b (word_next)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_peak_value  = value_ff;
   assign rsp_peak_row    = prow_ff;
   assign rsp_peak_col    = pcol_ff;

endmodule

`default_nettype wire

// ===== design/fnlm_checker.sv =====
`default_nettype none

`include "four_neighbour_local_maximum_core_defines.svh"

module fnlm_checker #(
   parameter int MAX_COLS   = 64,
   parameter int MAX_ROWS   = 64,
   parameter int DATA_WIDTH = 16
) (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire fnlm_pkg::result_kind_type         rsp_result_kind,
   input wire logic signed [DATA_WIDTH-1:0]      rsp_peak_value,
   input wire logic [$clog2(MAX_ROWS+1)-1:0]     rsp_peak_row,
   input wire logic [$clog2(MAX_COLS+1)-1:0]     rsp_peak_col
);

   `FNLM_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "rsp_valid after reset")

   `FNLM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_peak_value) && $stable(rsp_result_kind) && $stable(rsp_peak_row) && $stable(rsp_peak_col), "stalled rsp transfer changed")

   `FNLM_ASSERT(a_end_zero, rsp_valid && rsp_result_kind != fnlm_pkg::KIND_PEAK |-> rsp_peak_value == '0, "end item carries a value")

   `FNLM_ASSERT(a_peak_interior, rsp_valid && rsp_result_kind == fnlm_pkg::KIND_PEAK |-> rsp_peak_row >= 2 && rsp_peak_col >= 2, "peak on a border")

   `FNLM_ASSERT(a_no_overrun, req_valid && req_ready |-> !rsp_valid || rsp_ready, "req transfer while rsp stalled")

endmodule

bind four_neighbour_local_maximum_core fnlm_checker #(
   .MAX_COLS   (MAX_COLS),
   .MAX_ROWS   (MAX_ROWS),
   .DATA_WIDTH (DATA_WIDTH)
) u_fnlm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_kind (rsp_result_kind),
   .rsp_peak_value  (rsp_peak_value),
   .rsp_peak_row    (rsp_peak_row),
   .rsp_peak_col    (rsp_peak_col)
);

`default_nettype wire
